// File: design/storage_port_init_handshake_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the storage port init handshake unit
// Concurrent checks on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef STORAGE_PORT_INIT_HANDSHAKE_UNIT_MACROS_SVH
`define STORAGE_PORT_INIT_HANDSHAKE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SPIH_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("spih assertion failed");

// next-cycle implication
`define SPIH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spih assertion failed");

`else

`define SPIH_ASSERT_NOW(lbl, ante, cons)
`define SPIH_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: design/spih_pkg.sv
// ----------------------------------------------------------------------------
// spih_pkg
// Types and constants shared by the storage port init handshake unit.
// ----------------------------------------------------------------------------
`default_nettype none

package spih_pkg;

    localparam int OUT_ADDR_W = 22;

    // host access codes
    typedef enum logic [1:0] {
        CMD_READ     = 2'd0,
        CMD_WRITE    = 2'd1,
        CMD_WRITE_LO = 2'd2,
        CMD_WRITE_HI = 2'd3
    } t_command;

    localparam logic SEL_IP = 1'b0;
    localparam logic SEL_SA = 1'b1;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_DEFAULT_VECTOR   = 2'd0,
        CFG_PORT_MODEL       = 2'd1,
        CFG_FIRMWARE_VERSION = 2'd2,
        CFG_UNUSED           = 2'd3
    } t_cfg_index;

    localparam logic [8:0] DEFAULT_VECTOR_RST   = 9'd108;
    localparam logic [3:0] PORT_MODEL_RST       = 4'd6;
    localparam logic [3:0] FIRMWARE_VERSION_RST = 4'd3;

    // status word bits
    localparam logic [15:0] SA_ERR  = 16'h8000;
    localparam logic [15:0] SA_S1   = 16'h0800;
    localparam logic [15:0] SA_S2   = 16'h1000;
    localparam logic [15:0] SA_S3   = 16'h2000;
    localparam logic [15:0] SA_S4   = 16'h4000;
    localparam logic [15:0] SA_DIAG = 16'h0100;
    localparam logic [15:0] SA_MAP  = 16'h0040;
    localparam logic [15:0] SA_RESET = SA_S1 | SA_DIAG | SA_MAP;
    localparam logic [15:0] SA_DEAD  = SA_ERR | 16'h0001;

    // visible step codes
    localparam logic [2:0] ST_STEP1    = 3'd0;
    localparam logic [2:0] ST_WRAP     = 3'd1;
    localparam logic [2:0] ST_STEP2    = 3'd2;
    localparam logic [2:0] ST_STEP3    = 3'd3;
    localparam logic [2:0] ST_PURGE_SA = 3'd4;
    localparam logic [2:0] ST_PURGE_IP = 3'd5;
    localparam logic [2:0] ST_STEP4    = 3'd6;
    localparam logic [2:0] ST_RUN      = 3'd7;

    typedef struct packed {
        logic             we;
        t_cfg_index       index;
        logic [8:0]       wdata;
    } t_cfg_write;

    typedef struct packed {
        logic [15:0]           read_data;
        logic [2:0]            controller_state;
        logic                  irq_request;
        logic [8:0]            irq_vector;
        logic                  poll_request;
        logic                  clear_request;
        logic [OUT_ADDR_W-1:0] clear_start;
        logic [10:0]           clear_bytes;
        logic [OUT_ADDR_W-1:0] response_ring_base;
        logic [OUT_ADDR_W-1:0] command_ring_base;
        logic [7:0]            command_ring_slots;
        logic [7:0]            response_ring_slots;
    } t_result;

endpackage

`default_nettype wire

// File: design/spih_port.sv
// ----------------------------------------------------------------------------
// spih_port
// Step sequencer: updates the port state on each accepted host access and
// forms the result beat for it in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module spih_port #(
    parameter int ADDRESS_BITS = 22
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic [1:0]           i_command,
    input  wire logic                 i_reg_select,
    input  wire logic [15:0]          i_write_data,
    input  wire spih_pkg::t_cfg_write i_cfg,
    output spih_pkg::t_result         o_result
);

    typedef enum logic [8:0] {
        PH_STEP1    = 9'b000000001,
        PH_WRAP     = 9'b000000010,
        PH_STEP2    = 9'b000000100,
        PH_STEP3    = 9'b000001000,
        PH_PURGE_SA = 9'b000010000,
        PH_PURGE_IP = 9'b000100000,
        PH_STEP4    = 9'b001000000,
        PH_RUN      = 9'b010000000,
        PH_DEAD     = 9'b100000000
    } t_phase;

    localparam int AW = ADDRESS_BITS;

    t_phase          r_phase,    n_phase;
    logic [15:0]     r_status,   n_status;
    logic [15:0]     r_pending,  n_pending;
    logic [7:0]      r_step1_hi, n_step1_hi;
    logic [8:0]      r_vector,   n_vector;
    logic            r_irq_en,   n_irq_en;
    logic            r_purge_en, n_purge_en;
    logic [AW-1:0]   r_comm,     n_comm;
    logic [2:0]      r_cmd_code, n_cmd_code;
    logic [2:0]      r_rsp_code, n_rsp_code;

    logic [8:0]      r_dflt_vec;
    logic [3:0]      r_model;
    logic [3:0]      r_fw;

    logic [15:0]     sa_word;
    logic [31:0]     lo_word;
    logic [31:0]     hi_word;
    logic            post;
    logic            enter4;
    logic            ev_poll;
    logic            ev_irq;
    logic [15:0]     rd;
    logic [7:0]      rsp_slots;
    logic [7:0]      cmd_slots;
    logic [9:0]      rsp_bytes;
    logic [9:0]      cmd_bytes;
    logic [3:0]      clr_off;
    logic [AW-1:0]   cmd_base;
    logic [AW-1:0]   clr_base;
    logic [31:0]     comm_ext;
    logic [31:0]     cmd_base_ext;
    logic [31:0]     clr_base_ext;
    logic [2:0]      state_code;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dflt_vec <= spih_pkg::DEFAULT_VECTOR_RST;
            r_model    <= spih_pkg::PORT_MODEL_RST;
            r_fw       <= spih_pkg::FIRMWARE_VERSION_RST;
        end else if (i_cfg.we) begin
            unique case (i_cfg.index)
                spih_pkg::CFG_DEFAULT_VECTOR:   r_dflt_vec <= i_cfg.wdata;
                spih_pkg::CFG_PORT_MODEL:       r_model    <= i_cfg.wdata[3:0];
                spih_pkg::CFG_FIRMWARE_VERSION: r_fw       <= i_cfg.wdata[3:0];
                default: ;
            endcase
        end
    end

    // merged SA word for this access
    always_comb begin
        unique case (spih_pkg::t_command'(i_command))
            spih_pkg::CMD_WRITE:    sa_word = i_write_data;
            spih_pkg::CMD_WRITE_LO: sa_word = {r_pending[15:8], i_write_data[7:0]};
            spih_pkg::CMD_WRITE_HI: sa_word = {i_write_data[7:0], r_pending[7:0]};
            default:                sa_word = r_pending;
        endcase
    end

    assign lo_word = {16'h0000, sa_word[15:1], 1'b0};
    assign hi_word = {1'b0, sa_word[14:0], 16'h0000};

    always_comb begin
        n_phase    = r_phase;
        n_status   = r_status;
        n_pending  = r_pending;
        n_step1_hi = r_step1_hi;
        n_vector   = r_vector;
        n_irq_en   = r_irq_en;
        n_purge_en = r_purge_en;
        n_comm     = r_comm;
        n_cmd_code = r_cmd_code;
        n_rsp_code = r_rsp_code;
        post       = 1'b0;
        enter4     = 1'b0;
        ev_poll    = 1'b0;
        rd         = 16'h0000;

        if (i_accept) begin
            if (spih_pkg::t_command'(i_command) == spih_pkg::CMD_READ) begin
                if (i_reg_select == spih_pkg::SEL_IP) begin
                    if (r_phase == PH_PURGE_IP) begin
                        enter4 = 1'b1;
                    end else if (r_phase == PH_RUN) begin
                        ev_poll = 1'b1;
                    end
                end else begin
                    rd = r_status;
                end
            end else if (i_reg_select == spih_pkg::SEL_IP) begin
                // port reset
                n_phase    = PH_STEP1;
                n_status   = spih_pkg::SA_RESET;
                n_pending  = 16'h0000;
                n_step1_hi = 8'h00;
                n_vector   = r_dflt_vec;
                n_irq_en   = 1'b0;
                n_purge_en = 1'b0;
                n_comm     = '0;
                n_cmd_code = 3'd0;
                n_rsp_code = 3'd0;
            end else begin
                n_pending = sa_word;
                unique case (r_phase)
                    PH_STEP1: begin
                        if (sa_word[15]) begin
                            if (sa_word[14]) begin
                                n_status = sa_word;
                                n_phase  = PH_WRAP;
                            end else begin
                                n_step1_hi = sa_word[15:8];
                                n_cmd_code = sa_word[13:11];
                                n_rsp_code = sa_word[10:8];
                                n_irq_en   = sa_word[7];
                                if (sa_word[6:0] != 7'd0) begin
                                    n_vector = {sa_word[6:0], 2'b00};
                                end
                                n_status = spih_pkg::SA_S2 | {8'h00, sa_word[15:8]};
                                n_phase  = PH_STEP2;
                                post     = 1'b1;
                            end
                        end
                    end
                    PH_WRAP: begin
                        n_status = sa_word;
                    end
                    PH_STEP2: begin
                        n_comm     = lo_word[AW-1:0];
                        n_purge_en = sa_word[0];
                        n_status   = spih_pkg::SA_S3 | {8'h00, r_step1_hi};
                        n_phase    = PH_STEP3;
                        post       = 1'b1;
                    end
                    PH_STEP3: begin
                        n_comm = r_comm | hi_word[AW-1:0];
                        if (sa_word[15]) begin
                            n_status = 16'h0000;
                            n_phase  = PH_PURGE_SA;
                        end else begin
                            enter4 = 1'b1;
                        end
                    end
                    PH_PURGE_SA: begin
                        if (sa_word != 16'h0000) begin
                            n_status = spih_pkg::SA_DEAD;
                            n_phase  = PH_DEAD;
                        end else begin
                            n_phase = PH_PURGE_IP;
                        end
                    end
                    PH_STEP4: begin
                        if (sa_word[0]) begin
                            n_status = 16'h0000;
                            n_phase  = PH_RUN;
                            ev_poll  = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end

        if (enter4) begin
            n_status = spih_pkg::SA_S4 | {8'h00, r_model, r_fw};
            n_phase  = PH_STEP4;
            post     = 1'b1;
        end
    end

    assign ev_irq = post && n_irq_en && (n_vector != 9'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_STEP1;
            r_status   <= spih_pkg::SA_RESET;
            r_pending  <= 16'h0000;
            r_step1_hi <= 8'h00;
            r_vector   <= spih_pkg::DEFAULT_VECTOR_RST;
            r_irq_en   <= 1'b0;
            r_purge_en <= 1'b0;
            r_comm     <= '0;
            r_cmd_code <= 3'd0;
            r_rsp_code <= 3'd0;
        end else begin
            r_phase    <= n_phase;
            r_status   <= n_status;
            r_pending  <= n_pending;
            r_step1_hi <= n_step1_hi;
            r_vector   <= n_vector;
            r_irq_en   <= n_irq_en;
            r_purge_en <= n_purge_en;
            r_comm     <= n_comm;
            r_cmd_code <= n_cmd_code;
            r_rsp_code <= n_rsp_code;
        end
    end

    // ring geometry from the updated state
    assign rsp_slots = 8'd1 << n_rsp_code;
    assign cmd_slots = 8'd1 << n_cmd_code;
    assign rsp_bytes = {rsp_slots, 2'b00};
    assign cmd_bytes = {cmd_slots, 2'b00};
    assign clr_off   = n_purge_en ? 4'd8 : 4'd4;
    assign cmd_base  = n_comm + AW'(rsp_bytes);
    assign clr_base  = n_comm - AW'(clr_off);

    assign comm_ext     = 32'(n_comm);
    assign cmd_base_ext = 32'(cmd_base);
    assign clr_base_ext = 32'(clr_base);

    always_comb begin
        unique case (n_phase)
            PH_STEP1:    state_code = spih_pkg::ST_STEP1;
            PH_WRAP:     state_code = spih_pkg::ST_WRAP;
            PH_STEP2:    state_code = spih_pkg::ST_STEP2;
            PH_STEP3:    state_code = spih_pkg::ST_STEP3;
            PH_PURGE_SA: state_code = spih_pkg::ST_PURGE_SA;
            PH_PURGE_IP: state_code = spih_pkg::ST_PURGE_IP;
            PH_STEP4:    state_code = spih_pkg::ST_STEP4;
            PH_RUN:      state_code = spih_pkg::ST_RUN;
            PH_DEAD:     state_code = spih_pkg::ST_PURGE_SA;
            default:     state_code = spih_pkg::ST_STEP1;
        endcase
    end

    always_comb begin
        o_result.read_data           = rd;
        o_result.controller_state    = state_code;
        o_result.irq_request         = ev_irq;
        o_result.irq_vector          = ev_irq ? n_vector : 9'd0;
        o_result.poll_request        = ev_poll;
        o_result.clear_request       = enter4;
        o_result.clear_start         = enter4 ? clr_base_ext[spih_pkg::OUT_ADDR_W-1:0] : '0;
        o_result.clear_bytes         = enter4 ?
                                       (11'(clr_off) + 11'(rsp_bytes) + 11'(cmd_bytes)) :
                                       11'd0;
        o_result.response_ring_base  = comm_ext[spih_pkg::OUT_ADDR_W-1:0];
        o_result.command_ring_base   = cmd_base_ext[spih_pkg::OUT_ADDR_W-1:0];
        o_result.command_ring_slots  = cmd_slots;
        o_result.response_ring_slots = rsp_slots;
    end

endmodule

`default_nettype wire

// File: design/spih_obuf.sv
// ----------------------------------------------------------------------------
// spih_obuf
// Result register with a skid stage: takes a beat while the previous one
// still waits downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module spih_obuf (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire spih_pkg::t_result i_data,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output spih_pkg::t_result      o_data
);

    logic              r_out_valid,  n_out_valid;
    logic              r_skid_valid, n_skid_valid;
    spih_pkg::t_result r_out,        n_out;
    spih_pkg::t_result r_skid,       n_skid;
    logic              accept;
    logic              out_free;

    assign accept   = i_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (out_free) begin
            if (r_skid_valid) begin
                // drain skid into the output slot
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (accept) begin
                n_out       = i_data;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (accept) begin
            // hold output, park the new beat
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_stall = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

// File: design/storage_port_init_handshake_unit.sv
// ----------------------------------------------------------------------------
// storage_port_init_handshake_unit
// Port-side IP/SA initialization handshake of a disk controller.
// ----------------------------------------------------------------------------
//  channel   valid         stall         payload
//  access    i_in_valid    o_in_stall    i_command, i_reg_select, i_write_data
//  result    o_out_valid   i_out_stall   o_read_data ... o_response_ring_slots
//  config    i_cfg_we      (none)        i_cfg_index, i_cfg_wdata
//
// One access per cycle while o_in_stall is low; its result is registered.
// The step state updates in the accept cycle, so the next access sees it.
// A result register plus one skid stage absorb a downstream stall; the
// input stalls only when both are full.
// Synchronous active-low reset restores step 1 and the config defaults.
// ----------------------------------------------------------------------------
`default_nettype none

`include "storage_port_init_handshake_unit_macros.svh"

module storage_port_init_handshake_unit #(
    parameter int ADDRESS_BITS = 22
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [8:0]  i_cfg_wdata,

    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic        i_reg_select,
    input  wire logic [15:0] i_write_data,

    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [15:0]      o_read_data,
    output logic [2:0]       o_controller_state,
    output logic             o_irq_request,
    output logic [8:0]       o_irq_vector,
    output logic             o_poll_request,
    output logic             o_clear_request,
    output logic [21:0]      o_clear_start,
    output logic [10:0]      o_clear_bytes,
    output logic [21:0]      o_response_ring_base,
    output logic [21:0]      o_command_ring_base,
    output logic [7:0]       o_command_ring_slots,
    output logic [7:0]       o_response_ring_slots
);

    spih_pkg::t_cfg_write cfg;
    spih_pkg::t_result    step_result;
    spih_pkg::t_result    out_result;
    logic                 accept;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = spih_pkg::t_cfg_index'(i_cfg_index);
    assign cfg.wdata = i_cfg_wdata;

    assign accept = i_in_valid && !o_in_stall;

    spih_port #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_port (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_command    (i_command),
        .i_reg_select (i_reg_select),
        .i_write_data (i_write_data),
        .i_cfg        (cfg),
        .o_result     (step_result)
    );

    spih_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (step_result),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_result)
    );

    assign o_read_data           = out_result.read_data;
    assign o_controller_state    = out_result.controller_state;
    assign o_irq_request         = out_result.irq_request;
    assign o_irq_vector          = out_result.irq_vector;
    assign o_poll_request        = out_result.poll_request;
    assign o_clear_request       = out_result.clear_request;
    assign o_clear_start         = out_result.clear_start;
    assign o_clear_bytes         = out_result.clear_bytes;
    assign o_response_ring_base  = out_result.response_ring_base;
    assign o_command_ring_base   = out_result.command_ring_base;
    assign o_command_ring_slots  = out_result.command_ring_slots;
    assign o_response_ring_slots = out_result.response_ring_slots;

    // skid holds a beat only behind a full output slot
    `SPIH_ASSERT_NOW(a_skid_behind_out, o_in_stall, o_out_valid)
    // after every accepted access the output holds a valid beat next cycle
    `SPIH_ASSERT_NEXT(a_accept_gives_result, accept, o_out_valid)
    // clear window only on entering step 4
    `SPIH_ASSERT_NOW(a_clear_in_step4, o_out_valid && o_clear_request,
                     o_controller_state == spih_pkg::ST_STEP4)
    // an interrupt always carries a vector
    `SPIH_ASSERT_NOW(a_irq_has_vector, o_out_valid && o_irq_request,
                     o_irq_vector != 9'd0)

endmodule

`default_nettype wire
